// File: src/sed444_pkg.sv
// shared constants, types and state codes for the serpentine error diffusion block
// no dependencies; used by every module of the block
package sed444_pkg;

	localparam int LINE_WIDTH_W      = 11;
	localparam int DEFAULT_MAX_WIDTH = 1024;
	localparam int PIX_W             = 8;
	localparam int ERR_W             = 16;
	localparam int CHANNELS          = 3;
	localparam int QUEUE_DEPTH       = 4;

	// quantizer constants
	localparam int          LEVEL_ROUND = 8;
	localparam int          PIX_MAX     = 255;
	localparam logic [7:0]  LEVEL_MASK  = 8'hF0;
	localparam logic [7:0]  LEVEL_MAX   = 8'hF0;

	// diffusion weights, shares are weight/16 truncated toward zero
	localparam logic [2:0] WT_AHEAD  = 3'd7;
	localparam logic [2:0] WT_BEHIND = 3'd3;
	localparam logic [2:0] WT_BELOW  = 3'd5;
	localparam logic [2:0] WT_DIAG   = 3'd1;
	localparam int         SHARE_SHIFT = 4;

	typedef logic signed [ERR_W-1:0] err_t;
	typedef err_t [CHANNELS-1:0] err_vec_t;

	// classification of one pixel, made by the front end
	typedef struct packed {
		logic start;   // first pixel of a row, carry comes from the line
		logic prime;   // window must be reloaded before this pixel
		logic last;    // last pixel of the row
		logic back;    // row runs right to left
	} pix_class_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_RUN,
		BK_FLUSH0,
		BK_FLUSH1,
		BK_PRIME0,
		BK_PRIME1,
		BK_PRIME2
	} bk_state_t;

endpackage

// File: src/serpentine_error_diffusion_rgb444.sv
// top level of the serpentine floyd-steinberg reducer, rgb888 to rgb444
// depends on sed444_pkg, sed444_front, sed444_queue and sed444_back
//
// Pixels of a row enter one per transaction in scan order; right_to_left is
// sampled on the first pixel of each row and the row runs in that direction.
// Each channel is quantized to a multiple of 16 and the error is spread with
// weights 7, 3, 5 and 1 sixteenths into a carried error and a per-channel
// error line of MAX_WIDTH+2 signed 16-bit entries that accumulate over rows.
// Rate: one pixel per clock inside a row while out_stall is low. The carry
// loop (quantize, error, 7/16 share, saturate) feeds the carry register
// combinationally, and the line memory reads one entry ahead and writes one
// entry behind per pixel. At each row start, and whenever a width change
// moves the scan entry mid-row, the back end sees the reload request, writes
// the held window back with 2 flush writes and reloads it with 3 reads; the
// first row after reset skips the flush. The front end and a 4-deep queue
// keep taking pixels meanwhile. After reset the line memory is cleared one
// entry per cycle, all MAX_WIDTH+2 entries, while in_stall is high.
// line_width is taken at any time (cfg_ready is always high) but should be
// written only while no pixel is in flight.
module serpentine_error_diffusion_rgb444 #(
	parameter int MAX_WIDTH = sed444_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sed444_pkg::LINE_WIDTH_W-1:0] line_width,
	// pixel input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sed444_pkg::PIX_W-1:0]        red_in,
	input  logic [sed444_pkg::PIX_W-1:0]        green_in,
	input  logic [sed444_pkg::PIX_W-1:0]        blue_in,
	input  logic                                right_to_left,
	// pixel output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sed444_pkg::PIX_W-1:0]        red_out,
	output logic [sed444_pkg::PIX_W-1:0]        green_out,
	output logic [sed444_pkg::PIX_W-1:0]        blue_out,
	output logic                                row_end
);

	localparam int AW  = $clog2(MAX_WIDTH + 2);
	localparam int LW  = sed444_pkg::LINE_WIDTH_W;
	localparam int PXW = sed444_pkg::PIX_W;
	localparam int CLW = $bits(sed444_pkg::pix_class_t);
	localparam int QW  = AW + CLW + 3 * PXW;
	// reset width, limited to what the register can hold
	localparam int RESET_WIDTH = (MAX_WIDTH > (2 ** LW - 1)) ? (2 ** LW - 1) : MAX_WIDTH;

	logic [LW-1:0] line_width_q;

	logic                   take;
	logic                   q_full;
	logic                   clearing;
	sed444_pkg::pix_class_t f_cls;
	logic [AW-1:0]          f_j;
	logic [QW-1:0]          push_data;
	logic [QW-1:0]          head_data;
	logic                   head_valid;
	logic                   pop;
	sed444_pkg::pix_class_t h_cls;
	logic [AW-1:0]          h_j;
	logic [PXW-1:0]         h_red;
	logic [PXW-1:0]         h_green;
	logic [PXW-1:0]         h_blue;

	// width register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LW'(RESET_WIDTH);
		end else if (cfg_valid && cfg_ready) begin
			line_width_q <= line_width;
		end
	end

	// input side stalls on a full queue and during the clearing pass
	assign in_stall = q_full || clearing;
	assign take     = in_valid && !in_stall;

	sed444_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.line_width   (line_width_q),
		.take         (take),
		.right_to_left(right_to_left),
		.cls          (f_cls),
		.j            (f_j)
	);

	// classified pixel: line entry, class, then the three components
	assign push_data = {f_j, f_cls, red_in, green_in, blue_in};

	sed444_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.wdata     (push_data),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head_data)
	);

	assign {h_j, h_cls, h_red, h_green, h_blue} = head_data;

	sed444_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_cls  (h_cls),
		.head_j    (h_j),
		.head_red  (h_red),
		.head_green(h_green),
		.head_blue (h_blue),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.row_end   (row_end),
		.clearing  (clearing)
	);

endmodule

// File: src/sed444_front.sv
// front end: row position tracking and pixel classification
// depends on sed444_pkg
module sed444_front #(
	parameter int MAX_WIDTH = sed444_pkg::DEFAULT_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH + 2)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [sed444_pkg::LINE_WIDTH_W-1:0] line_width,
	input  logic                                take,
	input  logic                                right_to_left,
	output sed444_pkg::pix_class_t              cls,
	output logic [AW-1:0]                       j
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int LW = sed444_pkg::LINE_WIDTH_W;
	localparam int CW = ((WW > LW) ? WW : LW) + 1;
	localparam int PW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [PW-1:0] pos_q;
	logic          row_backward_q;
	logic [AW-1:0] prev_j_q;

	logic [CW-1:0] lw_ext;
	logic [CW-1:0] w_eff;
	logic [CW-1:0] w_m1;
	logic [CW-1:0] pos_raw;
	logic [CW-1:0] pos;
	logic [CW-1:0] idx;
	logic [CW-1:0] j_full;
	logic [CW-1:0] pos_next;
	logic [AW-1:0] expect_j;
	logic          start;
	logic          last;
	logic          back;
	logic          jump;

	always_comb begin
		lw_ext = CW'(line_width);
		if (lw_ext == '0) begin
			w_eff = CW'(1);
		end else if (lw_ext > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = lw_ext;
		end
		w_m1    = w_eff - CW'(1);
		pos_raw = CW'(pos_q);
		// position past a shrunken width is taken as the last pixel
		pos     = (pos_raw > w_m1) ? w_m1 : pos_raw;
		start   = (pos == '0);
		last    = (pos == w_m1);
		back    = start ? right_to_left : row_backward_q;
		idx     = back ? (w_m1 - pos) : pos;
		j_full  = idx + CW'(1);
		j       = j_full[AW-1:0];
		expect_j = back ? (prev_j_q - AW'(1)) : (prev_j_q + AW'(1));
		// a width change can move the scan entry off the running window
		jump    = !start && (j != expect_j);
		pos_next = last ? '0 : (pos + CW'(1));
		cls.start = start;
		cls.prime = start || jump;
		cls.last  = last;
		cls.back  = back;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			row_backward_q <= 1'b0;
		end else if (take) begin
			pos_q          <= pos_next[PW-1:0];
			row_backward_q <= back;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			prev_j_q <= j;
		end
	end

endmodule

// File: src/sed444_queue.sv
// short first-in first-out queue between the front end and the back end
// depends on sed444_pkg for its depth
module sed444_queue #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output logic [WIDTH-1:0] head
);

	localparam int DEPTH = sed444_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		bump = (p == PTR_W'(DEPTH - 1)) ? '0 : (p + PTR_W'(1));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: src/sed444_back.sv
// back end: error line memory, three-entry window, quantizer and diffusion
// depends on sed444_pkg
module sed444_back #(
	parameter int MAX_WIDTH = sed444_pkg::DEFAULT_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH + 2)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  sed444_pkg::pix_class_t       head_cls,
	input  logic [AW-1:0]                head_j,
	input  logic [sed444_pkg::PIX_W-1:0] head_red,
	input  logic [sed444_pkg::PIX_W-1:0] head_green,
	input  logic [sed444_pkg::PIX_W-1:0] head_blue,
	output logic                         pop,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [sed444_pkg::PIX_W-1:0] red_out,
	output logic [sed444_pkg::PIX_W-1:0] green_out,
	output logic [sed444_pkg::PIX_W-1:0] blue_out,
	output logic                         row_end,
	output logic                         clearing
);

	localparam int DEPTH = MAX_WIDTH + 2;
	localparam int PXW   = sed444_pkg::PIX_W;
	localparam int ERW   = sed444_pkg::ERR_W;
	localparam int EW    = PXW + 2;
	localparam int PRW   = EW + 4;
	localparam int NCH   = sed444_pkg::CHANNELS;

	// quantizer: level of x plus carried error, clamped to the 4-bit range
	function automatic logic [PXW-1:0] quant_level(input logic [PXW-1:0] x,
	                                               input sed444_pkg::err_t e);
		logic signed [ERW+1:0] c;
		c = $signed({{(ERW + 2 - PXW){1'b0}}, x}) + $signed({{2{e[ERW-1]}}, e})
		  + $signed((ERW + 2)'(sed444_pkg::LEVEL_ROUND));
		if (c[ERW+1] || (c == '0)) begin
			quant_level = '0;
		end else if (c > $signed((ERW + 2)'(sed444_pkg::PIX_MAX))) begin
			quant_level = sed444_pkg::LEVEL_MAX;
		end else begin
			quant_level = c[PXW-1:0] & sed444_pkg::LEVEL_MASK;
		end
	endfunction

	// err * k / 16, truncated toward zero
	function automatic logic signed [EW-1:0] share(input logic signed [EW-1:0] err,
	                                               input logic [2:0] k);
		logic signed [PRW-1:0] p;
		logic signed [PRW-1:0] b;
		logic signed [PRW-1:0] s;
		p = $signed({{(PRW - EW){err[EW-1]}}, err}) * $signed({{(PRW - 3){1'b0}}, k});
		b = p + (p[PRW-1] ? PRW'((1 << sed444_pkg::SHARE_SHIFT) - 1) : PRW'(0));
		s = b >>> sed444_pkg::SHARE_SHIFT;
		share = s[EW-1:0];
	endfunction

	// saturating add into a 16-bit error entry
	function automatic sed444_pkg::err_t sat_add(input sed444_pkg::err_t a,
	                                             input logic signed [EW-1:0] d);
		logic signed [ERW:0] sum;
		sum = $signed({a[ERW-1], a}) + $signed({{(ERW + 1 - EW){d[EW-1]}}, d});
		if (sum[ERW] != sum[ERW-1]) begin
			sat_add = sum[ERW] ? {1'b1, {(ERW - 1){1'b0}}} : {1'b0, {(ERW - 1){1'b1}}};
		end else begin
			sat_add = sum[ERW-1:0];
		end
	endfunction

	sed444_pkg::bk_state_t st_q;
	sed444_pkg::bk_state_t st_d;

	logic [AW-1:0]        clr_q;
	logic                 primed_q;
	logic                 win_valid_q;
	logic                 out_valid_q;
	sed444_pkg::err_vec_t wb_q;
	sed444_pkg::err_vec_t wc_q;
	sed444_pkg::err_vec_t carry_q;
	sed444_pkg::err_vec_t rdata_q;
	logic [AW-1:0]        wb_addr_q;
	logic [AW-1:0]        wc_addr_q;
	logic [PXW-1:0]       red_q;
	logic [PXW-1:0]       green_q;
	logic [PXW-1:0]       blue_q;
	logic                 row_end_q;

	sed444_pkg::err_vec_t line_mem [DEPTH];

	logic                 we;
	logic [AW-1:0]        waddr;
	sed444_pkg::err_vec_t wdata;
	logic                 ren;
	logic [AW-1:0]        raddr;

	logic                 out_free;
	logic                 need_prime;
	logic                 go;
	logic [AW-1:0]        behind_addr;
	logic [AW-1:0]        ahead_addr;
	logic [AW-1:0]        next_ahead_addr;

	logic [PXW-1:0]        x_v [NCH];
	logic [PXW-1:0]        q_v [NCH];
	logic signed [EW-1:0]  err_v [NCH];
	sed444_pkg::err_t      carry_use [NCH];
	sed444_pkg::err_vec_t  behind_new;
	sed444_pkg::err_vec_t  cur_new;
	sed444_pkg::err_vec_t  ahead_new;
	sed444_pkg::err_vec_t  carry_nx;

	assign out_free   = !out_valid_q || !out_stall;
	assign need_prime = head_cls.prime && !primed_q;
	assign go         = (st_q == sed444_pkg::BK_RUN) && head_valid && !need_prime && out_free;

	assign behind_addr     = head_cls.back ? (head_j + AW'(1)) : (head_j - AW'(1));
	assign ahead_addr      = head_cls.back ? (head_j - AW'(1)) : (head_j + AW'(1));
	assign next_ahead_addr = head_cls.back ? (head_j - AW'(2)) : (head_j + AW'(2));

	assign x_v[0] = head_red;
	assign x_v[1] = head_green;
	assign x_v[2] = head_blue;

	// per-channel datapath, channels are independent
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			carry_use[c]  = head_cls.start ? wc_q[c] : carry_q[c];
			q_v[c]        = quant_level(x_v[c], carry_use[c]);
			err_v[c]      = $signed({2'b00, x_v[c]}) - $signed({2'b00, q_v[c]});
			behind_new[c] = sat_add(wb_q[c], share(err_v[c], sed444_pkg::WT_BEHIND));
			cur_new[c]    = sat_add(wc_q[c], share(err_v[c], sed444_pkg::WT_BELOW));
			ahead_new[c]  = sat_add(rdata_q[c], share(err_v[c], sed444_pkg::WT_DIAG));
			carry_nx[c]   = sat_add(rdata_q[c], share(err_v[c], sed444_pkg::WT_AHEAD));
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			sed444_pkg::BK_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					st_d = sed444_pkg::BK_RUN;
				end
			end
			sed444_pkg::BK_RUN: begin
				if (head_valid && need_prime) begin
					st_d = win_valid_q ? sed444_pkg::BK_FLUSH0 : sed444_pkg::BK_PRIME0;
				end
			end
			sed444_pkg::BK_FLUSH0: st_d = sed444_pkg::BK_FLUSH1;
			sed444_pkg::BK_FLUSH1: st_d = sed444_pkg::BK_PRIME0;
			sed444_pkg::BK_PRIME0: st_d = sed444_pkg::BK_PRIME1;
			sed444_pkg::BK_PRIME1: st_d = sed444_pkg::BK_PRIME2;
			sed444_pkg::BK_PRIME2: st_d = sed444_pkg::BK_RUN;
			default:               st_d = sed444_pkg::BK_CLEAR;
		endcase
	end

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		ren   = 1'b0;
		raddr = '0;
		pop   = 1'b0;
		case (st_q)
			sed444_pkg::BK_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			sed444_pkg::BK_RUN: begin
				if (go) begin
					we    = 1'b1;
					waddr = behind_addr;
					wdata = behind_new;
					ren   = !head_cls.last;
					raddr = next_ahead_addr;
					pop   = 1'b1;
				end
			end
			sed444_pkg::BK_FLUSH0: begin
				we    = 1'b1;
				waddr = wb_addr_q;
				wdata = wb_q;
			end
			sed444_pkg::BK_FLUSH1: begin
				we    = 1'b1;
				waddr = wc_addr_q;
				wdata = wc_q;
			end
			sed444_pkg::BK_PRIME0: begin
				ren   = 1'b1;
				raddr = behind_addr;
			end
			sed444_pkg::BK_PRIME1: begin
				ren   = 1'b1;
				raddr = head_j;
			end
			sed444_pkg::BK_PRIME2: begin
				ren   = 1'b1;
				raddr = ahead_addr;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= sed444_pkg::BK_CLEAR;
			clr_q       <= '0;
			primed_q    <= 1'b0;
			win_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == sed444_pkg::BK_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (st_q == sed444_pkg::BK_PRIME2) begin
				primed_q <= 1'b1;
			end else if (go) begin
				primed_q <= 1'b0;
			end
			if (go) begin
				win_valid_q <= 1'b1;
			end
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == sed444_pkg::BK_PRIME1) begin
			wb_q <= rdata_q;
		end else if (st_q == sed444_pkg::BK_PRIME2) begin
			wc_q <= rdata_q;
		end else if (go) begin
			wb_q      <= cur_new;
			wc_q      <= ahead_new;
			wb_addr_q <= head_j;
			wc_addr_q <= ahead_addr;
			carry_q   <= carry_nx;
			red_q     <= q_v[0];
			green_q   <= q_v[1];
			blue_q    <= q_v[2];
			row_end_q <= head_cls.last;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			line_mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= line_mem[raddr];
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign row_end   = row_end_q;
	assign clearing  = (st_q == sed444_pkg::BK_CLEAR);

	a_pop_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (st_q == sed444_pkg::BK_RUN) && out_free)
		else $error("pixel taken outside run state or into a full output register");

	a_window_primed: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_cls.prime) |-> primed_q)
		else $error("pixel needing a fresh window used a stale one");

	a_no_port_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(we && ren) |-> (waddr != raddr))
		else $error("line memory read and write at the same entry");

	a_pop_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("processed pixel did not reach the output register");

endmodule

// File: tb/sv/tb_serpentine_error_diffusion_rgb444.sv
// self-checking testbench for the serpentine rgb444 error diffusion block
// predicts every dithered pixel in sv and checks each output transaction in order
// depends on sed444_pkg and serpentine_error_diffusion_rgb444
module tb_serpentine_error_diffusion_rgb444;

	localparam int MAX_WIDTH  = sed444_pkg::DEFAULT_MAX_WIDTH;
	localparam int LINE_DEPTH = MAX_WIDTH + 2;
	localparam int CYCLE_CAP  = 1_500_000;
	localparam int RANDOM_PIXELS = 1100;
	localparam int SAT_PIXELS    = 100;

	// channel slots in the predicted error state
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	// how the components of one row are chosen
	typedef enum int {
		SHADE_ANY,
		SHADE_CORNER,
		SHADE_EDGE,
		SHADE_FLAT
	} shade_mode_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       row_end;
	} dithered_px_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [sed444_pkg::LINE_WIDTH_W-1:0] line_width;
	logic in_valid;
	logic in_stall;
	logic [sed444_pkg::PIX_W-1:0] red_in;
	logic [sed444_pkg::PIX_W-1:0] green_in;
	logic [sed444_pkg::PIX_W-1:0] blue_in;
	logic right_to_left;
	logic out_valid;
	logic out_stall;
	logic [sed444_pkg::PIX_W-1:0] red_out;
	logic [sed444_pkg::PIX_W-1:0] green_out;
	logic [sed444_pkg::PIX_W-1:0] blue_out;
	logic row_end;

	// predicted block state: error lines with padding, carried errors, scan position
	sed444_pkg::err_t err_line [sed444_pkg::CHANNELS][LINE_DEPTH];
	sed444_pkg::err_t carry_err [sed444_pkg::CHANNELS];
	int           scan_pos;
	logic         row_back;
	logic [sed444_pkg::LINE_WIDTH_W-1:0] width_reg;

	dithered_px_t expected_px [$];
	int           fail_count;
	int           result_count;
	int           cycle_count;

	// idling level per side: 0 none, 1 sparse gaps, 2 a random gap drawn for every transaction
	int send_idle;
	int recv_idle;
	int stall_left;
	int hold_left;

	always #5 clk = ~clk;

	serpentine_error_diffusion_rgb444 #(
		.MAX_WIDTH(MAX_WIDTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.line_width   (line_width),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.right_to_left(right_to_left),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.row_end      (row_end)
	);

	function automatic int pick_wait(input int level);
		case (level)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 13)) : 0;
			default: return int'($urandom_range(0, 13));
		endcase
	endfunction

	function automatic sed444_pkg::err_t clamp16(input int v);
		if (v > 32767)
			return sed444_pkg::err_t'(32767);
		if (v < -32768)
			return sed444_pkg::err_t'(-32768);
		return sed444_pkg::err_t'(v);
	endfunction

	// quantize one channel at line entry j and push its error into carry and line
	function automatic logic [7:0] diffuse_channel(input int ch, input logic [7:0] x,
			input int j, input logic back);
		int sum;
		int err;
		int ahead;
		int behind;
		logic [7:0] level;
		sum = int'(x) + int'(carry_err[ch]) + 8;
		if (sum <= 0)
			level = 8'h00;
		else if (sum > 255)
			level = 8'hF0;
		else
			level = sum[7:0] & 8'hF0;
		// the spread error leaves the carried error out
		err    = int'(x) - int'(level);
		ahead  = back ? j - 1 : j + 1;
		behind = back ? j + 1 : j - 1;
		// carry reads the ahead entry before its own 1/16 share lands
		carry_err[ch]          = clamp16(int'(err_line[ch][ahead]) + err * 7 / 16);
		err_line[ch][behind]   = clamp16(int'(err_line[ch][behind]) + err * 3 / 16);
		err_line[ch][j]        = clamp16(int'(err_line[ch][j]) + err * 5 / 16);
		err_line[ch][ahead]    = clamp16(int'(err_line[ch][ahead]) + err / 16);
		return level;
	endfunction

	function automatic void predict_pixel(input logic [7:0] r, g, b, input logic dir);
		int w;
		int pos;
		int first;
		int j;
		int ch;
		dithered_px_t px;
		w = int'(width_reg);
		if (w < 1)
			w = 1;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		// a width shrunk below the position closes the row on this pixel
		pos = scan_pos;
		if (pos > w - 1)
			pos = w - 1;
		if (pos == 0) begin
			row_back = dir;
			first = row_back ? w : 1;
			for (ch = 0; ch < sed444_pkg::CHANNELS; ch++)
				carry_err[ch] = err_line[ch][first];
		end
		j = (row_back ? (w - 1 - pos) : pos) + 1;
		px.red     = diffuse_channel(CH_RED, r, j, row_back);
		px.green   = diffuse_channel(CH_GREEN, g, j, row_back);
		px.blue    = diffuse_channel(CH_BLUE, b, j, row_back);
		px.row_end = (pos == w - 1);
		scan_pos = px.row_end ? 0 : pos + 1;
		expected_px.push_back(px);
	endfunction

	function automatic logic [7:0] pick_shade(input shade_mode_t mode, input logic [7:0] flat);
		logic [7:0] corners [8];
		corners = '{8'd0, 8'd255, 8'd7, 8'd8, 8'd247, 8'd248, 8'd15, 8'd16};
		case (mode)
			SHADE_ANY:    return 8'($urandom);
			SHADE_CORNER: return corners[$urandom_range(0, 7)];
			// just around a rounding threshold
			SHADE_EDGE:   return 8'($urandom_range(0, 15) * 16 + $urandom_range(6, 9));
			default:      return flat;
		endcase
	endfunction

	// one pixel transaction, predicted when the block takes it
	task automatic send_pixel(input logic [7:0] r, g, b, input logic dir);
		int gap;
		gap = pick_wait(send_idle);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		red_in        <= r;
		green_in      <= g;
		blue_in       <= b;
		right_to_left <= dir;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_pixel(r, g, b, dir);
	endtask

	// drop valid and wait for every predicted pixel to come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_px.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_line_width(input logic [sed444_pkg::LINE_WIDTH_W-1:0] w);
		cfg_valid  <= 1'b1;
		line_width <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		width_reg = w;
	endtask

	// direction only counts on the first pixel, the rest get random bits
	task automatic send_row(input int count, input logic dir);
		shade_mode_t mode;
		logic [7:0] flat;
		int k;
		mode = shade_mode_t'($urandom_range(0, 3));
		flat = 8'($urandom);
		for (k = 0; k < count; k++)
			send_pixel(pick_shade(mode, flat), pick_shade(mode, flat), pick_shade(mode, flat),
				(k == 0) ? dir : 1'($urandom_range(0, 1)));
	endtask

	// extremes of every component, both directions, odd widths and mid-row changes
	task automatic test_directed_extremes();
		send_idle = 2;
		recv_idle = 2;
		// reset width, a backward row starts at the far end of the line
		send_pixel(8'd255, 8'd0, 8'd128, 1'b1);
		send_pixel(8'd0, 8'd255, 8'd7, 1'b0);
		send_pixel(8'd8, 8'd247, 8'd248, 1'b1);
		wait_drained();
		// shrink below the scan position, next pixel closes the row
		write_line_width(11'd2);
		send_pixel(8'd15, 8'd16, 8'd240, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		wait_drained();
		// zero width acts as one pixel per row
		write_line_width(11'd0);
		send_pixel(8'd247, 8'd8, 8'd127, 1'b1);
		send_pixel(8'd248, 8'd7, 8'd128, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
		wait_drained();
		// all ones is clamped to the line size
		write_line_width(11'h7FF);
		send_pixel(8'd1, 8'd254, 8'd129, 1'b0);
		send_pixel(8'd254, 8'd1, 8'd126, 1'b1);
		wait_drained();
		// position stays inside the new row
		write_line_width(11'd4);
		send_pixel(8'd240, 8'd239, 8'd241, 1'b1);
		send_pixel(8'd16, 8'd23, 8'd24, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
		send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd128, 8'd127, 8'd136, 1'b1);
		send_pixel(8'd31, 8'd32, 8'd33, 1'b0);
		wait_drained();
	endtask

	// long receiver hold-off while the sender keeps offering pixels
	task automatic test_back_pressure();
		int k;
		write_line_width(11'd16);
		send_idle = 0;
		recv_idle = 0;
		hold_left = 300;
		for (k = 0; k < 64; k++)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
		wait_drained();
	endtask

	task automatic test_random_rows();
		int sent;
		int rows;
		int w;
		int r;
		int part;
		// one full row at the largest width
		send_idle = 1;
		recv_idle = 1;
		write_line_width(11'(MAX_WIDTH));
		send_row(MAX_WIDTH, 1'($urandom_range(0, 1)));
		sent = MAX_WIDTH;
		wait_drained();
		while (sent < RANDOM_PIXELS) begin
			send_idle = $urandom_range(0, 2);
			recv_idle = $urandom_range(0, 2);
			case ($urandom_range(0, 9))
				0: w = $urandom_range(1, 3);
				1: w = 0;
				default: w = $urandom_range(1, 40);
			endcase
			write_line_width(11'(w));
			if (w == 0)
				w = 1;
			rows = $urandom_range(1, 4);
			for (r = 0; r < rows; r++)
				send_row(w, 1'($urandom_range(0, 1)));
			sent += rows * w;
			// a partial row makes the next width write land mid-row
			if ($urandom_range(0, 2) == 0) begin
				part = $urandom_range(1, w);
				send_row(part, 1'($urandom_range(0, 1)));
				sent += part;
			end
			wait_drained();
		end
	endtask

	// bright single-pixel rows pile error into one entry
	task automatic test_saturation();
		int k;
		write_line_width(11'd1);
		send_idle = 0;
		recv_idle = 0;
		for (k = 0; k < SAT_PIXELS; k++)
			send_pixel(8'd255, 8'd255, 8'd255, 1'($urandom_range(0, 1)));
		wait_drained();
	endtask

	// receiver: random stall after each transaction, or a long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall) begin
				stall_left = pick_wait(recv_idle);
				out_stall <= (stall_left != 0);
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= (stall_left != 0);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result checker, oldest prediction first
	always @(posedge clk) begin
		dithered_px_t want;
		dithered_px_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.red     = red_out;
			got.green   = green_out;
			got.blue    = blue_out;
			got.row_end = row_end;
			result_count++;
			if (expected_px.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("result %0d with no pixel pending: r=%0d g=%0d b=%0d end=%b",
						result_count, got.red, got.green, got.blue, got.row_end);
			end else begin
				want = expected_px.pop_front();
				if (got.red != want.red || got.green != want.green || got.blue != want.blue ||
						got.row_end != want.row_end) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result %0d: expected r=%0d g=%0d b=%0d end=%b, got r=%0d g=%0d b=%0d end=%b",
							result_count, want.red, want.green, want.blue, want.row_end,
							got.red, got.green, got.blue, got.row_end);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_CAP) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int ch;
		int k;
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		line_width    <= '0;
		in_valid      <= 1'b0;
		red_in        <= '0;
		green_in      <= '0;
		blue_in       <= '0;
		right_to_left <= 1'b0;
		out_stall     <= 1'b0;
		for (ch = 0; ch < sed444_pkg::CHANNELS; ch++) begin
			carry_err[ch] = '0;
			for (k = 0; k < LINE_DEPTH; k++)
				err_line[ch][k] = '0;
		end
		scan_pos     = 0;
		row_back     = 1'b0;
		width_reg    = 11'(MAX_WIDTH);
		fail_count   = 0;
		result_count = 0;
		cycle_count  = 0;
		stall_left   = 0;
		hold_left    = 0;
		send_idle    = 0;
		recv_idle    = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_extremes();
		test_back_pressure();
		test_random_rows();
		test_saturation();
		// room for any stray result after the last expected one
		repeat (32) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
